// ===== rtl/core/msac_pkg.sv =====
`default_nettype none
package msac_pkg;

  localparam int NUM_PARAMS = 64;
  localparam int IDX_W      = $clog2(NUM_PARAMS);
  localparam int FRAC_BITS  = 24;

  // log2(e) in Q2.30
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

  // config register indexes
  localparam logic [1:0] REG_GAIN      = 2'd0;
  localparam logic [1:0] REG_TARGET    = 2'd1;
  localparam logic [1:0] REG_THETA_MIN = 2'd2;
  localparam logic [1:0] REG_THETA_MAX = 2'd3;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SET    = 1'b1;

  typedef logic [31:0] ctab_t [FRAC_BITS];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    vv = v;
    b  = 64'd1 << 62;
    while (b > vv) b = b >> 2;
    while (b != 0) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // c[j] = 2^(2^-(j+1)) in Q2.30; entry j serves fraction bit FRAC_BITS-1-j
  function automatic ctab_t gen_exp_tab();
    ctab_t       t;
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int j = 0; j < FRAC_BITS; j++) begin
      t[j] = c[31:0];
      c    = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam ctab_t EXP_TAB = gen_exp_tab();

endpackage
`default_nettype wire

// ===== rtl/core/move_size_acceptance_controller.sv =====
`default_nettype none
// Adaptive step-size controller. Holds one Q16.16 theta bar per parameter.
// An op-0 beat (accept/move counts) scales theta bar by
// exp(gain*(ratio-target)); an op-1 beat loads theta bar. Every beat yields
// exactly one result beat: theta clamped to [theta_min, theta_max], shown for
// one cycle under out_valid. The receiver cannot stall, so sample it then.
// An op-1 beat writes the store and goes straight to the emit step; a
// zero-move beat reads theta bar and emits. When accepted >= total the ratio
// saturates and the divide is skipped; a full update runs a 16-step
// compare-subtract divide and a 24-step exp2 product on one shared 32x32
// multiplier under the sequencer. busy falls on the edge that raises
// out_valid, so the next beat can be taken at the edge that ends the result.
// busy is high for the whole of a beat; start is taken only when busy is low.
// Entries never loaded with op 1 hold undefined values until written.
module move_size_acceptance_controller
  import msac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              in_op,
  input  wire logic [IDX_W-1:0]  in_param_index,
  input  wire logic [31:0]       in_accept_count,
  input  wire logic [31:0]       in_move_count,
  input  wire logic [31:0]       in_theta_value,
  output      logic              out_valid,
  output      logic [31:0]       out_actual_theta,
  output      logic [15:0]       out_acceptance_ratio,
  output      logic              out_no_moves,
  output      logic              out_theta_saturated,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [31:0]       cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_MX    = 4'd3;
  localparam logic [3:0] S_MY    = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_EXP   = 4'd6;
  localparam logic [3:0] S_MT    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  // config
  logic [15:0] gain_r, target_r;
  logic [31:0] tmin_r, tmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= 16'd256;
      target_r <= 16'd29491;
      tmin_r   <= 32'd1;
      tmax_r   <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN:      gain_r   <= cfg_wdata[15:0];
        REG_TARGET:    target_r <= cfg_wdata[15:0];
        REG_THETA_MIN: tmin_r   <= cfg_wdata;
        REG_THETA_MAX: tmax_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [3:0]       state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      acc_r, acc_nxt, mov_r, mov_nxt;
  logic [32:0]      rem_r, rem_nxt;
  logic [15:0]      ratio_r, ratio_nxt;
  logic             nomv_r, nomv_nxt, sat_r, sat_nxt;
  logic [63:0]      mul_r, mul_nxt;
  logic [31:0]      m_r, m_nxt;
  logic [FRAC_BITS-1:0] f_r, f_nxt;
  logic signed [10:0] n_r, n_nxt;
  logic [31:0]      theta_r, theta_nxt;
  logic [31:0]      rd_r;

  logic             ov_r, ov_nxt;
  logic [31:0]      oth_r, oth_nxt;
  logic [15:0]      orat_r, orat_nxt;
  logic             onm_r, onm_nxt, osat_r, osat_nxt;

  // theta store: one write, one registered read
  logic [31:0]      mem [NUM_PARAMS];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end
  always_ff @(posedge clk) begin
    rd_r <= mem[in_param_index];
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // helpers
  logic        neg;
  logic [15:0] diff;
  logic [32:0] trial;
  logic [63:0] rnd29;
  logic [32:0] ymag;
  logic [8:0]  nmag;
  logic signed [10:0] s_l;
  logic [94:0] shl;
  logic [63:0] shr;
  logic [31:0] fin_val;
  logic        fin_sat;
  logic [31:0] clamp_lo;

  function automatic logic [31:0] rnd_q30(input logic [63:0] p);
    logic [63:0] t;
    t = p + (64'd1 << 29);
    return t[61:30];
  endfunction

  assign neg   = ratio_r < target_r;
  assign diff  = neg ? (target_r - ratio_r) : (ratio_r - target_r);
  assign trial = {rem_r[31:0], 1'b0};
  assign rnd29 = mul_r + (64'd1 << 29);
  assign ymag  = rnd29[62:30];
  assign nmag  = ymag[32:FRAC_BITS];

  always_comb begin
    mul_a = m_r;
    mul_b = EXP_TAB[cnt_r];
    unique case (state_r)
      S_MX: begin
        mul_a = {16'd0, diff};
        mul_b = {16'd0, gain_r};
      end
      S_MY: begin
        mul_a = mul_r[31:0];
        mul_b = LOG2E_Q30;
      end
      S_MT: begin
        mul_a = theta_r;
        mul_b = m_r;
      end
      default: ;
    endcase
  end

  // final scale by 2^n: left or right shift, saturating on overflow; a zero result becomes 1
  always_comb begin
    fin_sat = 1'b0;
    fin_val = 32'd0;
    shl     = '0;
    shr     = '0;
    s_l     = 11'sd0;
    if (n_r >= 11'sd30) begin
      s_l = n_r - 11'sd30;
      shl = {31'd0, mul_r} << s_l[4:0];
      if (mul_r == 64'd0) begin
        fin_val = 32'd0;
      end else if (s_l >= 11'sd32 || shl[94:32] != '0) begin
        fin_sat = 1'b1;
        fin_val = 32'hFFFF_FFFF;
      end else begin
        fin_val = shl[31:0];
      end
    end else begin
      s_l = 11'sd30 - n_r;
      shr = (s_l >= 11'sd64) ? 64'd0 : (mul_r >> s_l[5:0]);
      if (shr[63:32] != '0) begin
        fin_sat = 1'b1;
        fin_val = 32'hFFFF_FFFF;
      end else begin
        fin_val = shr[31:0];
      end
    end
    if (!fin_sat && fin_val == 32'd0) begin
      fin_sat = 1'b1;
      fin_val = 32'd1;
    end
  end

  assign clamp_lo = (theta_r < tmin_r) ? tmin_r : theta_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    mov_nxt   = mov_r;
    rem_nxt   = rem_r;
    ratio_nxt = ratio_r;
    nomv_nxt  = nomv_r;
    sat_nxt   = sat_r;
    mul_nxt   = mul_r;
    m_nxt     = m_r;
    f_nxt     = f_r;
    n_nxt     = n_r;
    theta_nxt = theta_r;
    ov_nxt    = 1'b0;
    oth_nxt   = oth_r;
    orat_nxt  = orat_r;
    onm_nxt   = onm_r;
    osat_nxt  = osat_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = fin_val;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt   = in_param_index;
          acc_nxt   = in_accept_count;
          mov_nxt   = in_move_count;
          ratio_nxt = 16'd0;
          sat_nxt   = 1'b0;
          nomv_nxt  = 1'b0;
          if (in_op == OP_SET) begin
            wr_en     = 1'b1;
            wr_addr   = in_param_index;
            wr_data   = (in_theta_value == 32'd0) ? 32'd1 : in_theta_value;
            theta_nxt = wr_data;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        theta_nxt = rd_r;
        cnt_nxt   = 5'd0;
        rem_nxt   = {1'b0, acc_r};
        if (mov_r == 32'd0) begin
          nomv_nxt  = 1'b1;
          state_nxt = S_EMIT;
        end else if (acc_r >= mov_r) begin
          ratio_nxt = 16'hFFFF;
          state_nxt = S_MX;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, mov_r}) begin
          rem_nxt   = trial - {1'b0, mov_r};
          ratio_nxt = {ratio_r[14:0], 1'b1};
        end else begin
          rem_nxt   = trial;
          ratio_nxt = {ratio_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) state_nxt = S_MX;
      end
      S_MX: begin
        mul_nxt   = mul_p;
        state_nxt = S_MY;
      end
      S_MY: begin
        mul_nxt   = mul_p;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        m_nxt   = 32'd1 << 30;
        cnt_nxt = 5'd0;
        if (!neg) begin
          n_nxt = 11'($unsigned(nmag));
          f_nxt = ymag[FRAC_BITS-1:0];
        end else if (ymag[FRAC_BITS-1:0] != '0) begin
          n_nxt = -11'($unsigned(nmag)) - 11'sd1;
          f_nxt = FRAC_BITS'((25'd1 << FRAC_BITS) - {1'b0, ymag[FRAC_BITS-1:0]});
        end else begin
          n_nxt = -11'($unsigned(nmag));
          f_nxt = '0;
        end
        state_nxt = S_EXP;
      end
      S_EXP: begin
        if (f_r[FRAC_BITS-1]) m_nxt = rnd_q30(mul_p);
        f_nxt   = {f_r[FRAC_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(FRAC_BITS - 1)) state_nxt = S_MT;
      end
      S_MT: begin
        mul_nxt   = mul_p;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        wr_en     = 1'b1;
        theta_nxt = fin_val;
        sat_nxt   = fin_sat;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ov_nxt    = 1'b1;
        oth_nxt   = (clamp_lo > tmax_r) ? tmax_r : clamp_lo;
        orat_nxt  = ratio_r;
        onm_nxt   = nomv_r;
        osat_nxt  = sat_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    acc_r   <= acc_nxt;
    mov_r   <= mov_nxt;
    rem_r   <= rem_nxt;
    ratio_r <= ratio_nxt;
    nomv_r  <= nomv_nxt;
    sat_r   <= sat_nxt;
    mul_r   <= mul_nxt;
    m_r     <= m_nxt;
    f_r     <= f_nxt;
    n_r     <= n_nxt;
    theta_r <= theta_nxt;
    oth_r   <= oth_nxt;
    orat_r  <= orat_nxt;
    onm_r   <= onm_nxt;
    osat_r  <= osat_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = ov_r;
  assign out_actual_theta     = oth_r;
  assign out_acceptance_ratio = orat_r;
  assign out_no_moves         = onm_r;
  assign out_theta_saturated  = osat_r;

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EMIT))
    else $error("result beat without emit step");
  a_nomove_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_moves |-> out_acceptance_ratio == 16'd0 && !out_theta_saturated)
    else $error("no-move beat carries ratio or saturation");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < 5'd16)
    else $error("divide step count overrun");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

endmodule
`default_nettype wire

// ===== tb/sv/tb_move_size_acceptance_controller.sv =====
`default_nettype none

// Expected result beat for one accepted input beat.
typedef struct {
  logic [31:0] theta;
  logic [15:0] ratio;
  logic        no_moves;
  logic        sat;
} theta_result_t;

class theta_scoreboard;
  theta_result_t   pending_q[$];
  logic [31:0]     theta_bar [64];
  logic [15:0]     gain;
  logic [15:0]     target;
  logic [31:0]     theta_lo;
  logic [31:0]     theta_hi;
  longint unsigned root_tab [24];
  int              n_err;
  int              n_checked;

  function new();
    longint unsigned c;
    gain      = 16'd256;
    target    = 16'd29491;
    theta_lo  = 32'd1;
    theta_hi  = 32'hFFFF_FFFF;
    n_err     = 0;
    n_checked = 0;
    foreach (theta_bar[i]) theta_bar[i] = '0;
    // root_tab[j] = 2^(2^-(j+1)) in Q2.30, used for fraction bit 23-j
    c = int_sqrt(64'd1 << 61);
    for (int j = 0; j < 24; j++) begin
      root_tab[j] = c;
      c = int_sqrt(c << 30);
    end
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967295;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function void set_reg(logic [1:0] addr, logic [31:0] data);
    case (addr)
      msac_pkg::REG_GAIN:      gain     = data[15:0];
      msac_pkg::REG_TARGET:    target   = data[15:0];
      msac_pkg::REG_THETA_MIN: theta_lo = data;
      msac_pkg::REG_THETA_MAX: theta_hi = data;
      default: ;
    endcase
  endfunction

  // theta * exp(+/- xmag), xmag in Q8.24; sets sat on either format limit
  function logic [31:0] rescale(logic [31:0] theta, bit neg, longint unsigned xmag,
                                output bit sat);
    longint unsigned ymag, f, m, prod, res;
    longint          n, s;
    ymag = (xmag * 64'd1549082005 + (64'd1 << 29)) >> 30;
    f    = ymag & 64'hFF_FFFF;
    sat  = 0;
    if (!neg) begin
      n = longint'(ymag >> 24);
    end else begin
      n = -longint'(ymag >> 24);
      if (f != 0) begin
        n = n - 1;
        f = (64'd1 << 24) - f;
      end
    end
    m = 64'd1 << 30;
    for (int k = 23; k >= 0; k--)
      if (f[k]) m = (m * root_tab[23-k] + (64'd1 << 29)) >> 30;
    prod = longint'(theta) * m;
    if (n >= 30) begin
      s = n - 30;
      if (prod == 0) begin
        res = 0;
      end else if (s >= 32 || prod > (64'hFFFF_FFFF >> s)) begin
        sat = 1;
        return 32'hFFFF_FFFF;
      end else begin
        res = prod << s;
      end
    end else begin
      s   = 30 - n;
      res = (s >= 64) ? 0 : (prod >> s);
    end
    if (res > 64'hFFFF_FFFF) begin
      sat = 1;
      return 32'hFFFF_FFFF;
    end
    if (res == 0) begin
      sat = 1;
      return 32'd1;
    end
    return res[31:0];
  endfunction

  function void note_input(logic op, logic [5:0] idx, logic [31:0] acc,
                           logic [31:0] mov, logic [31:0] tv);
    theta_result_t   r;
    longint unsigned q, xmag;
    bit              neg, sat;
    logic [31:0]     act;
    r.ratio    = '0;
    r.no_moves = 0;
    r.sat      = 0;
    if (op == msac_pkg::OP_SET) begin
      theta_bar[idx] = (tv == 0) ? 32'd1 : tv;
    end else if (mov == 0) begin
      r.no_moves = 1;
    end else begin
      q = (longint'(acc) << 16) / longint'(mov);
      if (q > 64'hFFFF) q = 64'hFFFF;
      r.ratio = q[15:0];
      neg  = r.ratio < target;
      xmag = (neg ? longint'(target - r.ratio) : longint'(r.ratio - target))
             * longint'(gain);
      theta_bar[idx] = rescale(theta_bar[idx], neg, xmag, sat);
      r.sat = sat;
    end
    act = theta_bar[idx];
    if (act < theta_lo) act = theta_lo;
    if (act > theta_hi) act = theta_hi;
    r.theta = act;
    pending_q.push_back(r);
  endfunction

  function void check_result(logic [31:0] theta, logic [15:0] ratio,
                             logic no_moves, logic sat);
    theta_result_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result beat: theta=%h ratio=%h", theta, ratio);
      n_err++;
      return;
    end
    e = pending_q.pop_front();
    n_checked++;
    if (theta !== e.theta) begin
      $error("actual_theta: expected %h, got %h", e.theta, theta);
      n_err++;
    end
    if (ratio !== e.ratio) begin
      $error("acceptance_ratio: expected %h, got %h", e.ratio, ratio);
      n_err++;
    end
    if (no_moves !== e.no_moves) begin
      $error("no_moves: expected %b, got %b", e.no_moves, no_moves);
      n_err++;
    end
    if (sat !== e.sat) begin
      $error("theta_saturated: expected %b, got %b", e.sat, sat);
      n_err++;
    end
  endfunction
endclass

module tb_move_size_acceptance_controller;
  import msac_pkg::*;

  localparam int RUN_LIMIT = 2_000_000;  // watchdog limit, in cycles

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic              in_op = 0;
  logic [IDX_W-1:0]  in_param_index = '0;
  logic [31:0]       in_accept_count = '0;
  logic [31:0]       in_move_count = '0;
  logic [31:0]       in_theta_value = '0;
  logic              out_valid;
  logic [31:0]       out_actual_theta;
  logic [15:0]       out_acceptance_ratio;
  logic              out_no_moves;
  logic              out_theta_saturated;
  logic              cfg_we = 0;
  logic [1:0]        cfg_addr = '0;
  logic [31:0]       cfg_wdata = '0;

  theta_scoreboard sb = new();

  int  n_beats_in = 0;   // accepted input beats
  int  n_cycles = 0;
  int  n_updates = 0;
  int  n_sets = 0;
  bit  gaps_on = 1;
  bit  loaded [64];      // entries already written by op 1

  always #2 clk = ~clk;

  move_size_acceptance_controller dut (
    .clk, .rst_n, .start, .busy,
    .in_op, .in_param_index, .in_accept_count, .in_move_count, .in_theta_value,
    .out_valid, .out_actual_theta, .out_acceptance_ratio, .out_no_moves,
    .out_theta_saturated,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  // Monitor: inputs are stable at the rising edge (driven on the falling one).
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_input(in_op, in_param_index, in_accept_count, in_move_count,
                    in_theta_value);
      n_beats_in++;
    end
    if (rst_n && out_valid)
      sb.check_result(out_actual_theta, out_acceptance_ratio, out_no_moves,
                      out_theta_saturated);
  end

  // Watchdog.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 90);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  // Present one beat and hold it until taken; called at a falling edge.
  task automatic send(logic op, logic [5:0] idx, logic [31:0] acc,
                      logic [31:0] mov, logic [31:0] tv);
    int goal;
    int g;
    goal = n_beats_in + 1;
    start           <= 1'b1;
    in_op           <= op;
    in_param_index  <= idx;
    in_accept_count <= acc;
    in_move_count   <= mov;
    in_theta_value  <= tv;
    if (op == OP_SET) begin
      loaded[idx] = 1;
      n_sets++;
    end else begin
      n_updates++;
    end
    while (n_beats_in < goal) @(negedge clk);
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Drop start and drain every expected beat.
  task automatic quiesce();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(addr, data);
    @(negedge clk);
  endtask

  task automatic load_cfg(logic [15:0] g, logic [15:0] t, logic [31:0] lo,
                          logic [31:0] hi);
    quiesce();
    write_reg(REG_GAIN, {16'd0, g});
    write_reg(REG_TARGET, {16'd0, t});
    write_reg(REG_THETA_MIN, lo);
    write_reg(REG_THETA_MAX, hi);
  endtask

  // 32-bit value with a random magnitude so that small and huge both show up
  function automatic logic [31:0] rnd_mag();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic random_beats(int count);
    logic [5:0]  idx;
    logic [31:0] acc, mov;
    int          pick;
    for (int i = 0; i < count; i++) begin
      // occasional stretches with no idling at all
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      idx  = 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      // never read an entry that was never loaded
      if (!loaded[idx] || pick < 18) begin
        send(OP_SET, idx, $urandom, $urandom,
             ($urandom_range(0, 30) == 0) ? 32'd0 : rnd_mag());
      end else begin
        case ($urandom_range(0, 9))
          0:       mov = 32'd0;                      // no moves in the interval
          1:       mov = $urandom;
          2, 3:    mov = rnd_mag() | 32'd1;
          default: mov = $urandom_range(1, 2000);
        endcase
        case ($urandom_range(0, 9))
          0:       acc = $urandom;                   // may exceed the total
          1:       acc = mov + $urandom_range(1, 50);
          default: acc = (mov == 0) ? $urandom : $urandom_range(0, mov);
        endcase
        send(OP_UPDATE, idx, acc, mov, $urandom);
      end
    end
  endtask

  initial begin
    foreach (loaded[i]) loaded[i] = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed corner beats at reset configuration.
    send(OP_SET,    6'd0,  32'd0, 32'd0, 32'd0);           // zero load -> 1
    send(OP_UPDATE, 6'd0,  32'd5, 32'd10, 32'd0);          // bottom of range
    send(OP_SET,    6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_UPDATE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);  // ratio ~1
    send(OP_UPDATE, 6'd63, 32'd0, 32'hFFFF_FFFF, 32'd0);   // ratio 0
    send(OP_UPDATE, 6'd63, 32'd7, 32'd0, 32'd0);           // no moves
    send(OP_SET,    6'd21, 32'd0, 32'd0, 32'h0001_0000);   // theta 1.0
    send(OP_UPDATE, 6'd21, 32'd900, 32'd2, 32'd0);         // accepted > total
    send(OP_UPDATE, 6'd21, 32'd45, 32'd100, 32'd0);        // near target
    send(OP_UPDATE, 6'd21, 32'd1, 32'd1, 32'd0);
    send(OP_SET,    6'd42, 32'd0, 32'd0, 32'h8000_0000);
    send(OP_UPDATE, 6'd42, 32'd99, 32'd100, 32'd0);        // top of range
    send(OP_UPDATE, 6'd42, 32'd0, 32'd1, 32'd0);

    random_beats(300);
    load_cfg(16'd0, 16'd0, 32'd1, 32'hFFFF_FFFF);          // zero gain
    send(OP_UPDATE, 6'd21, 32'd0, 32'd3, 32'd0);
    random_beats(300);
    load_cfg(16'hFFFF, 16'hFFFF, 32'h0001_0000, 32'h0002_0000);
    random_beats(300);
    load_cfg(16'h0080, 16'h8000, 32'h0003_0000, 32'h0001_0000);  // min above max
    random_beats(300);
    load_cfg(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_beats(150);
    load_cfg(16'($urandom), 16'($urandom), $urandom_range(1, 32'h0001_0000),
             32'h0001_0000 + $urandom_range(0, 32'h7FFF_FFFF));
    random_beats(480);

    quiesce();
    repeat (60) @(negedge clk);

    $display("run covered %0d beats (%0d updates, %0d loads) over 6 register settings",
             n_beats_in, n_updates, n_sets);
    $display("%0d result beats checked, %0d field mismatches", sb.n_checked, sb.n_err);
    if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
